// ----- rtl/core/hsbc_pkg.sv -----
// Shared types, constants and tables of the hue/saturation brush color block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hsbc_pkg;

  localparam int HUE_ENTRIES = 256;
  localparam int HUE_AW      = (HUE_ENTRIES > 1) ? $clog2(HUE_ENTRIES) : 1;

  // Restoring divider: one quotient bit per stage, 8-bit quotients.
  localparam int DIV_STAGES = 8;
  localparam int SB_W       = 25;

  // Reciprocal multipliers for division by the constants 15 and 400.
  localparam logic [15:0] PULL_RECIP = 16'd34953;
  localparam int          PULL_SHIFT = 19;
  localparam logic [15:0] GRAY_RECIP = 16'd41944;
  localparam int          GRAY_SHIFT = 24;

  localparam logic [7:0] MID_LEVEL = 8'd84;

  typedef logic [2:0][15:0] num3_t;
  typedef logic [2:0][7:0]  chan3_t;
  typedef logic [SB_W-1:0]  sb_t;

  // floor(84 * (15 - sat) / 15) for each saturation level
  localparam logic [15:0][7:0] LO_TABLE = {
    8'd0,  8'd5,  8'd11, 8'd16, 8'd22, 8'd28, 8'd33, 8'd39,
    8'd44, 8'd50, 8'd56, 8'd61, 8'd67, 8'd72, 8'd78, 8'd84
  };

  typedef enum logic {
    ACT_COMPUTE = 1'b0,
    ACT_WRITE   = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    SIDE_0    = 2'd0,
    SIDE_1    = 2'd1,
    SIDE_2    = 2'd2,
    SIDE_NONE = 2'd3
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/hsbc_front.sv -----
// Front end: hue table, saturation pull toward mid level, channel placement and maximum.
// Depends on hsbc_pkg. Four register stages, all advanced by en.
`default_nettype none

module hsbc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic           in_action,
  input  wire logic [7:0]     in_hue_index,
  input  wire logic [7:0]     in_table_value,
  input  wire logic [1:0]     in_side,
  input  wire logic [3:0]     in_saturation,
  input  wire logic [5:0]     in_gray_target,
  output logic                out_valid,
  output hsbc_pkg::num3_t     out_num,
  output logic [7:0]          out_den,
  output logic [5:0]          out_target
);
  import hsbc_pkg::*;

  logic [7:0] hue_mem [HUE_ENTRIES];
  logic [HUE_AW-1:0] addr;
  logic in_range;

  assign addr     = HUE_AW'(in_hue_index);
  assign in_range = (32'(in_hue_index) < HUE_ENTRIES);

  // stage 1: table lookup
  logic       v1_r, rng1_r;
  logic [7:0] t1_r;
  logic [1:0] side1_r;
  logic [3:0] sat1_r;
  logic [5:0] tgt1_r;

  always_ff @(posedge clk) begin
    if (in_valid && en && (in_action == ACT_WRITE) && in_range) begin
      hue_mem[addr] <= in_table_value;
    end
    if (en) begin
      t1_r    <= hue_mem[addr];
      rng1_r  <= in_range;
      side1_r <= in_side;
      sat1_r  <= in_saturation;
      tgt1_r  <= in_gray_target;
    end
  end

  // stage 2: magnitude products sat*|c-84|
  logic [7:0] t2, u2, mag_t, mag_u;
  logic       neg_t, neg_u;
  always_comb begin
    t2    = rng1_r ? t1_r : 8'd0;
    u2    = 8'd255 - t2;
    neg_t = (t2 < MID_LEVEL);
    neg_u = (u2 < MID_LEVEL);
    mag_t = neg_t ? (MID_LEVEL - t2) : (t2 - MID_LEVEL);
    mag_u = neg_u ? (MID_LEVEL - u2) : (u2 - MID_LEVEL);
  end

  logic        v2_r, nt2_r, nu2_r;
  logic [11:0] mt2_r, mu2_r;
  logic [7:0]  lo2_r;
  logic [1:0]  side2_r;
  logic [5:0]  tgt2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mt2_r   <= 12'(sat1_r * mag_t);
      mu2_r   <= 12'(sat1_r * mag_u);
      nt2_r   <= neg_t;
      nu2_r   <= neg_u;
      lo2_r   <= LO_TABLE[sat1_r];
      side2_r <= side1_r;
      tgt2_r  <= tgt1_r;
    end
  end

  // stage 3: divide by 15 through the reciprocal, truncating toward zero
  logic [27:0] pt, pu;
  logic [7:0]  qt, qu;
  assign pt = 28'(mt2_r) * 28'(PULL_RECIP);
  assign pu = 28'(mu2_r) * 28'(PULL_RECIP);
  assign qt = 8'(pt >> PULL_SHIFT);
  assign qu = 8'(pu >> PULL_SHIFT);

  logic       v3_r;
  logic [7:0] ht3_r, hu3_r, lo3_r;
  logic [1:0] side3_r;
  logic [5:0] tgt3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ht3_r   <= nt2_r ? (MID_LEVEL - qt) : (MID_LEVEL + qt);
      hu3_r   <= nu2_r ? (MID_LEVEL - qu) : (MID_LEVEL + qu);
      lo3_r   <= lo2_r;
      side3_r <= side2_r;
      tgt3_r  <= tgt2_r;
    end
  end

  // stage 4: place channels, take maximum, form v*255
  chan3_t     rgb;
  logic [7:0] mx;
  always_comb begin
    case (side3_r)
      SIDE_0:  rgb = {lo3_r, ht3_r, hu3_r};
      SIDE_1:  rgb = {ht3_r, hu3_r, lo3_r};
      SIDE_2:  rgb = {hu3_r, lo3_r, ht3_r};
      default: rgb = '0;
    endcase
    mx = rgb[0];
    if (rgb[1] > mx) mx = rgb[1];
    if (rgb[2] > mx) mx = rgb[2];
  end

  logic       v4_r;
  num3_t      num4_r;
  logic [7:0] den4_r;
  logic [5:0] tgt4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num4_r[i] <= {rgb[i], 8'd0} - 16'(rgb[i]);
      end
      // all-zero channels divide by one to stay zero
      den4_r <= (mx == 8'd0) ? 8'd1 : mx;
      tgt4_r <= tgt3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid && (in_action == ACT_COMPUTE);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid  = v4_r;
  assign out_num    = num4_r;
  assign out_den    = den4_r;
  assign out_target = tgt4_r;

endmodule

`default_nettype wire

// ----- rtl/core/hsbc_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit a stage.
// Depends on hsbc_pkg. Quotients must fit in 8 bits.
`default_nettype none

module hsbc_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire hsbc_pkg::num3_t in_num,
  input  wire logic [7:0]      in_den,
  input  wire hsbc_pkg::sb_t   in_sb,
  output logic                 out_valid,
  output hsbc_pkg::chan3_t     out_quo,
  output hsbc_pkg::sb_t        out_sb
);
  import hsbc_pkg::*;

  logic [DIV_STAGES-1:0] vld_r;
  num3_t      rem_r [DIV_STAGES];
  chan3_t     quo_r [DIV_STAGES];
  logic [7:0] den_r [DIV_STAGES];
  sb_t        sb_r  [DIV_STAGES];

  num3_t      rem_nxt [DIV_STAGES];
  chan3_t     quo_nxt [DIV_STAGES];
  logic [7:0] den_src [DIV_STAGES];
  sb_t        sb_src  [DIV_STAGES];

  always_comb begin
    num3_t      src_rem;
    chan3_t     src_quo;
    logic [15:0] trial;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        src_rem    = in_num;
        src_quo    = '0;
        den_src[s] = in_den;
        sb_src[s]  = in_sb;
      end else begin
        src_rem    = rem_r[s-1];
        src_quo    = quo_r[s-1];
        den_src[s] = den_r[s-1];
        sb_src[s]  = sb_r[s-1];
      end
      trial = 16'(den_src[s]) << (DIV_STAGES - 1 - s);
      for (int l = 0; l < 3; l++) begin
        if (src_rem[l] >= trial) begin
          rem_nxt[s][l] = src_rem[l] - trial;
          quo_nxt[s][l] = src_quo[l] | (8'd1 << (DIV_STAGES - 1 - s));
        end else begin
          rem_nxt[s][l] = src_rem[l];
          quo_nxt[s][l] = src_quo[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      den_r <= den_src;
      sb_r  <= sb_src;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_quo   = quo_r[DIV_STAGES-1];
  assign out_sb    = sb_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/hsbc_gray.sv -----
// Gray level of the normalized color and set-up of the dimming division.
// Depends on hsbc_pkg. Three register stages, all advanced by en.
`default_nettype none

module hsbc_gray (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire hsbc_pkg::chan3_t in_full,
  input  wire logic [5:0]       in_target,
  output logic                  out_valid,
  output hsbc_pkg::num3_t       out_num,
  output logic [7:0]            out_den,
  output hsbc_pkg::sb_t         out_sb
);
  import hsbc_pkg::*;

  // stage 1: weighted sum
  logic        v1_r, v2_r, v3_r;
  logic [14:0] sum1_r;
  chan3_t      full1_r, full2_r;
  logic [5:0]  tgt1_r, tgt2_r;
  logic [30:0] prod2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum1_r  <= 15'(15'd30 * in_full[0]) + 15'(15'd59 * in_full[1])
               + 15'(15'd11 * in_full[2]);
      full1_r <= in_full;
      tgt1_r  <= in_target;
      // stage 2: divide by 400 through the reciprocal
      prod2_r <= 31'(sum1_r) * 31'(GRAY_RECIP);
      full2_r <= full1_r;
      tgt2_r  <= tgt1_r;
    end
  end

  // stage 3: compare and form numerators
  logic [5:0] gray;
  logic       dim;
  assign gray = prod2_r[GRAY_SHIFT+5:GRAY_SHIFT];
  assign dim  = (gray > tgt2_r);

  num3_t      num3_r;
  logic [7:0] den3_r;
  sb_t        sb3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num3_r[i] <= 16'(full2_r[i]) * 16'(tgt2_r);
      end
      den3_r <= (gray == 6'd0) ? 8'd1 : 8'(gray);
      sb3_r  <= {dim, full2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_num   = num3_r;
  assign out_den   = den3_r;
  assign out_sb    = sb3_r;

endmodule

`default_nettype wire

// ----- rtl/core/hue_saturation_brush_color_top.sv -----
// Top level of the hue/saturation brush color block: front end, two dividers, gray stage.
// Depends on hsbc_pkg, hsbc_front, hsbc_div and hsbc_gray.
//
// Usage:
//   Input channel in_*: one item per tvalid/tready handshake. in_tuser is the action:
//   ACT_WRITE stores table_value at hue_index in the hue table and gives no result;
//   ACT_COMPUTE gives one result item on out_*. Side three gives an all-zero result.
//   Entries of the hue table are undefined until written; read only written ones.
//   Output channel out_*: full (normalized to max 255) and dimmed (scaled to the gray
//   target) channels, in the order the compute items were accepted.
//   Path from input accept to out_tvalid: 4 front stages, 8 stages of the normalizing
//   divider, 3 gray stages, 8 stages of the dimming divider, one output register.
//   Throughput: one item per cycle while the receiver does not stall; every stage
//   holds one item and the dividers resolve one quotient bit per stage.
//   Stall: the whole pipeline advances together. While out_tvalid is high and
//   out_tready low, every stage holds and in_tready is low; nothing is lost or
//   repeated. Bubbles inside the pipeline are not filled during a stall.
//   Reset: rst_n (synchronous, active low) clears all valid bits; the hue table
//   keeps whatever it held.
`default_nettype none

module hue_saturation_brush_color_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] hue_index, [15:8] table_value, [17:16] side, [21:18] saturation,
  // [27:22] gray_target, [31:28] zero
  input  wire logic [31:0] in_tdata,
  // [0] action
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] red_full, [15:8] green_full, [23:16] blue_full,
  // [31:24] red_dimmed, [39:32] green_dimmed, [47:40] blue_dimmed
  output logic [47:0]      out_tdata
);
  import hsbc_pkg::*;

  logic en;

  // advance everything unless a finished result is waiting
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic       fr_valid;
  num3_t      fr_num;
  logic [7:0] fr_den;
  logic [5:0] fr_target;

  hsbc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_tvalid),
    .in_action      (in_tuser),
    .in_hue_index   (in_tdata[7:0]),
    .in_table_value (in_tdata[15:8]),
    .in_side        (in_tdata[17:16]),
    .in_saturation  (in_tdata[21:18]),
    .in_gray_target (in_tdata[27:22]),
    .out_valid      (fr_valid),
    .out_num        (fr_num),
    .out_den        (fr_den),
    .out_target     (fr_target)
  );

  logic   nd_valid;
  chan3_t nd_quo;
  sb_t    nd_sb;

  hsbc_div u_norm_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .in_sb     (SB_W'(fr_target)),
    .out_valid (nd_valid),
    .out_quo   (nd_quo),
    .out_sb    (nd_sb)
  );

  logic       gr_valid;
  num3_t      gr_num;
  logic [7:0] gr_den;
  sb_t        gr_sb;

  hsbc_gray u_gray (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nd_valid),
    .in_full   (nd_quo),
    .in_target (nd_sb[5:0]),
    .out_valid (gr_valid),
    .out_num   (gr_num),
    .out_den   (gr_den),
    .out_sb    (gr_sb)
  );

  logic   dd_valid;
  chan3_t dd_quo;
  sb_t    dd_sb;

  hsbc_div u_dim_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (gr_valid),
    .in_num    (gr_num),
    .in_den    (gr_den),
    .in_sb     (gr_sb),
    .out_valid (dd_valid),
    .out_quo   (dd_quo),
    .out_sb    (dd_sb)
  );

  // output register: keep full channels, take dimmed ones only above the target
  logic        out_valid_r;
  logic [47:0] out_data_r;
  chan3_t      full_c, dim_c;

  assign full_c = dd_sb[23:0];
  assign dim_c  = dd_sb[24] ? dd_quo : full_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {dim_c, full_c};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
